FILE: sv/mfhic_pkg.sv
// ----------------------------------------------------------------------------
// mfhic_pkg: shared constants and types for the magnetometer conditioner
// Widths, reset values, the reciprocal used for the window average and the
// configuration register map.
// ----------------------------------------------------------------------------
package mfhic_pkg;

    // Window and axis geometry
    localparam int WINDOW    = 10;
    localparam int AXES      = 3;

    // Field widths
    localparam int RAW_W     = 13;                          // sample width
    localparam int SUM_W     = RAW_W + $clog2(WINDOW) + 1;  // window sum
    localparam int EXT_W     = RAW_W + 1;                   // min/max/offset
    localparam int DIFF_W    = EXT_W + 1;                   // value - offset
    localparam int SCALE_W   = 16;                          // Q2.14 gain
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;        // signed product
    localparam int FRAC_DROP = 10;                          // Q.14 -> Q.4
    localparam int OUT_W     = 20;

    // Average by reciprocal: floor(n / WINDOW) == (n * DIV_MULT) >> DIV_SHIFT
    // for every window-sum magnitude.
    localparam int DIV_SHIFT = 24;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Stream packing
    localparam int IN_START_BIT  = AXES * RAW_W;
    localparam int IN_SAVE_BIT   = IN_START_BIT + 1;
    localparam int S_TDATA_W     = ((IN_SAVE_BIT + 1 + 7) / 8) * 8;
    localparam int OUT_CAL_BIT   = AXES * OUT_W;
    localparam int OUT_UPD_BIT   = OUT_CAL_BIT + 1;
    localparam int M_TDATA_W     = ((OUT_UPD_BIT + 1 + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = SCALE_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FILTER_EN = 2'd0,
        CFG_SCALE_X   = 2'd1,
        CFG_SCALE_Y   = 2'd2,
        CFG_SCALE_Z   = 2'd3
    } t_cfg_addr;

    // Reset values
    localparam logic [SCALE_W-1:0]    SCALE_ONE   = 16'd16384;
    localparam logic signed [EXT_W-1:0] MIN_INIT  = 14'sd4096;
    localparam logic signed [EXT_W-1:0] MAX_INIT  = -14'sd4096;
    localparam logic signed [EXT_W-1:0] OFF_INIT_X = 14'sd5;
    localparam logic signed [EXT_W-1:0] OFF_INIT_Y = -14'sd48;
    localparam logic signed [EXT_W-1:0] OFF_INIT_Z = 14'sd11;

endpackage

FILE: sv/magnetometer_filter_hard_iron_cal_top.sv
// ----------------------------------------------------------------------------
// magnetometer_filter_hard_iron_cal_top: three-axis magnetometer conditioner
// Moving-average filter, min/max hard-iron calibration and Q2.14 gain.
// ----------------------------------------------------------------------------
// One three-axis sample per stream transfer, one corrected sample out per
// transfer in, in order. The block takes a new sample every clock cycle
// unless output backpressure stalls it; a result passes four register
// stages in order (input stage, average, calibration update, scaling).
// Any stage frees up as soon as its content moves on, so bubbles collapse
// under output backpressure. The rate is held at one per cycle by a running
// window sum per axis, updated once per filtered transfer, and by
// single-step min/max tracking. Window taps and sums clear at reset and
// calibration state loads its reset values; no clearing pass follows.
// The user writes configuration only while the block is idle; the block does not enforce it.
module magnetometer_filter_hard_iron_cal_top
    import mfhic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // raw_x, raw_y, raw_z, start_calibration, save_calibration, zero pad
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // corrected stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // corrected_x, corrected_y, corrected_z, calibrating, offsets_updated, pad
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                       r_filter_en;
    logic [SCALE_W-1:0]         r_scale [AXES];

    logic signed [RAW_W-1:0]    r_win [AXES][WINDOW];
    logic signed [SUM_W-1:0]    r_sum [AXES];

    logic signed [EXT_W-1:0]    r_min [AXES];
    logic signed [EXT_W-1:0]    r_max [AXES];
    logic signed [EXT_W-1:0]    r_off [AXES];
    logic                       r_cal_active;

    logic                       r_a_valid;
    logic signed [SUM_W-1:0]    r_a_data [AXES];
    logic                       r_a_filt;
    logic                       r_a_start;
    logic                       r_a_save;

    logic                       r_b_valid;
    logic signed [RAW_W-1:0]    r_b_val [AXES];
    logic                       r_b_start;
    logic                       r_b_save;

    logic                       r_c_valid;
    logic signed [RAW_W-1:0]    r_c_val [AXES];
    logic                       r_c_cal;
    logic                       r_c_upd;

    logic                       r_out_valid;
    logic [M_TDATA_W-1:0]       r_out_data;

    logic                       en_a, en_b, en_c, en_out;
    logic                       s_xfer, b_go, b_cal;

    logic signed [RAW_W-1:0]    in_raw [AXES];
    logic                       in_start, in_save;
    logic signed [SUM_W-1:0]    n_sum [AXES];

    logic signed [RAW_W-1:0]    a_val [AXES];
    logic signed [EXT_W-1:0]    n_min [AXES];
    logic signed [EXT_W-1:0]    n_max [AXES];
    logic signed [EXT_W-1:0]    n_off [AXES];
    logic [OUT_W-1:0]           c_corr [AXES];

    // ------------------------------------------------------------------
    // Stage advance: each stage loads when empty or when it drains
    // ------------------------------------------------------------------
    assign en_out = !r_out_valid || i_m_axis_tready;
    assign en_c   = !r_c_valid   || en_out;
    assign en_b   = !r_b_valid   || en_c;
    assign en_a   = !r_a_valid   || en_b;
    assign s_xfer = i_s_axis_tvalid && en_a;
    assign b_go   = r_b_valid && en_c;

    assign o_s_axis_tready = en_a;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_scale[a] <= SCALE_ONE;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_FILTER_EN: r_filter_en <= i_cfg_wdata[0];
                CFG_SCALE_X:   r_scale[0]  <= i_cfg_wdata;
                CFG_SCALE_Y:   r_scale[1]  <= i_cfg_wdata;
                CFG_SCALE_Z:   r_scale[2]  <= i_cfg_wdata;
                default:       r_filter_en <= r_filter_en;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpack and running window sum
    // ------------------------------------------------------------------
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            in_raw[a] = i_s_axis_tdata[a*RAW_W +: RAW_W];
            n_sum[a]  = r_sum[a] - SUM_W'(r_win[a][0]) + SUM_W'(in_raw[a]);
        end
        in_start = i_s_axis_tdata[IN_START_BIT];
        in_save  = i_s_axis_tdata[IN_SAVE_BIT];
    end

    // window shifts only on filtered transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                for (int i = 0; i < WINDOW; i++) begin
                    r_win[a][i] <= '0;
                end
            end
        end else if (s_xfer && r_filter_en) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= n_sum[a];
                for (int i = 0; i < WINDOW - 1; i++) begin
                    r_win[a][i] <= r_win[a][i+1];
                end
                r_win[a][WINDOW-1] <= in_raw[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: window sum or raw sample
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            for (int a = 0; a < AXES; a++) begin
                r_a_data[a] <= r_filter_en ? n_sum[a] : SUM_W'(in_raw[a]);
            end
            r_a_filt  <= r_filter_en;
            r_a_start <= in_start;
            r_a_save  <= in_save;
        end
    end

    // ------------------------------------------------------------------
    // Average: magnitude times reciprocal, sign restored (toward zero)
    // ------------------------------------------------------------------
    always_comb begin
        logic                       neg;
        logic [SUM_W-1:0]           mag;
        logic [SUM_W+MULT_W-1:0]    prod;
        logic [EXT_W-1:0]           quo;
        logic [EXT_W-1:0]           sq;
        for (int a = 0; a < AXES; a++) begin
            neg  = r_a_data[a][SUM_W-1];
            mag  = neg ? SUM_W'(-r_a_data[a]) : SUM_W'(r_a_data[a]);
            prod = (SUM_W+MULT_W)'(mag) * (SUM_W+MULT_W)'(DIV_MULT);
            quo  = prod[DIV_SHIFT +: EXT_W];
            sq   = neg ? -quo : quo;
            a_val[a] = r_a_filt ? sq[RAW_W-1:0] : r_a_data[a][RAW_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: axis values
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && en_b) begin
            r_b_val   <= a_val;
            r_b_start <= r_a_start;
            r_b_save  <= r_a_save;
        end
    end

    // ------------------------------------------------------------------
    // Min/max tracking and offset midpoint (truncated toward zero)
    // ------------------------------------------------------------------
    assign b_cal = r_cal_active || r_b_start;

    always_comb begin
        logic signed [EXT_W-1:0] v;
        logic signed [EXT_W:0]   mid;
        for (int a = 0; a < AXES; a++) begin
            v        = EXT_W'(r_b_val[a]);
            n_min[a] = (b_cal && v < r_min[a]) ? v : r_min[a];
            n_max[a] = (b_cal && v > r_max[a]) ? v : r_max[a];
            mid      = (EXT_W+1)'(n_min[a]) + (EXT_W+1)'(n_max[a]);
            mid      = mid + (EXT_W+1)'(mid[EXT_W]);
            n_off[a] = mid[EXT_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_active <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_min[a] <= MIN_INIT;
                r_max[a] <= MAX_INIT;
            end
            r_off[0] <= OFF_INIT_X;
            r_off[1] <= OFF_INIT_Y;
            r_off[2] <= OFF_INIT_Z;
        end else if (b_go) begin
            r_cal_active <= b_cal && !r_b_save;
            r_min        <= n_min;
            r_max        <= n_max;
            if (r_b_save) begin
                r_off <= n_off;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: value and flags, offsets already current
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_c_val <= r_b_val;
            r_c_cal <= b_cal && !r_b_save;
            r_c_upd <= r_b_save;
        end
    end

    // ------------------------------------------------------------------
    // Offset removal and gain, floored to 4 fractional bits
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        for (int a = 0; a < AXES; a++) begin
            diff = DIFF_W'(r_c_val[a]) - DIFF_W'(r_off[a]);
            prod = PROD_W'(diff) * PROD_W'($signed({1'b0, r_scale[a]}));
            c_corr[a] = prod[FRAC_DROP +: OUT_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && en_out) begin
            r_out_data <= {(M_TDATA_W-OUT_UPD_BIT-1)'(0), r_c_upd, r_c_cal,
                           c_corr[2], c_corr[1], c_corr[0]};
        end
    end

`ifndef SYNTH
    // a save always leaves calibration mode
    a_save_ends_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_b_save) |=> !r_cal_active)
        else $error("calibration still active after save");

    // tracked extremes bound every calibrating sample (X axis)
    a_minmax_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && b_cal) |=> (r_min[0] <= $past(r_b_val[0])
                             && r_max[0] >= $past(r_b_val[0])))
        else $error("min/max not updated by calibrating sample");

    // a result that carries new offsets never reports calibrating
    a_out_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[OUT_UPD_BIT])
            |-> !o_m_axis_tdata[OUT_CAL_BIT])
        else $error("offsets updated while calibrating");
`endif

endmodule
